/* rtl/greedy_box_suppression_assert.svh */
// assertion macros for the greedy box suppression block
`ifndef GREEDY_BOX_SUPPRESSION_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_ASSERT_SVH
`ifndef SYNTHESIS
`define GBS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gbs assertion failed");
`define GBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gbs assertion failed");
`else
`define GBS_ASSERT(lbl, clk, rstn, prop)
`define GBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/gbs_pkg.sv */
// shared types and constants of the greedy box suppression block
`timescale 1ns / 1ps
package gbs_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned ClassW = 8;
  localparam int unsigned ThrW   = 16;
  localparam logic [ThrW-1:0] ThrReset = 16'd14746;

  typedef struct packed {
    logic [CoordW-1:0] h;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } geom_t;

  typedef struct packed {
    logic  valid;
    geom_t p;
    geom_t q;
  } ovl_req_t;

  typedef struct packed {
    logic valid;
    logic drop;
  } ovl_rsp_t;
endpackage

/* rtl/greedy_box_suppression.sv */
// top level of the greedy box suppression block
`timescale 1ns / 1ps
// greedy non-maximum suppression over one set of detection boxes
// input channel: one box word per accepted cycle (in_valid_i high, in_stall_o low);
//   set_end_i marks the last box of a set; boxes past MAX_BOXES are dropped
// output channel: one kept box word per out_valid_o, held while out_stall_i is high;
//   run_end_o marks the last kept box, emitted in descending score order
// config: cfg_we_i writes overlap_threshold (Q1.15); write only while idle
// in_stall_o is low only while loading
// after set_end the block ranks boxes by counting, reading scores through the single
//   read port of the score memory
// then each candidate in rank order is checked against the kept boxes in turn, through
//   the geometry memory port and the overlap pipeline; the check stops at the first kept
//   box that suppresses it, and the candidate is kept when none does
// a stall holds the output word and the whole sequencer
// reset clears counters and state; memories are not cleared, only loaded entries are read
module greedy_box_suppression #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gbs_pkg::ThrW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gbs_pkg::CoordW-1:0]   box_x_i,
  input  logic [gbs_pkg::CoordW-1:0]   box_y_i,
  input  logic [gbs_pkg::CoordW-1:0]   box_width_i,
  input  logic [gbs_pkg::CoordW-1:0]   box_height_i,
  input  logic [gbs_pkg::ScoreW-1:0]   score_i,
  input  logic [gbs_pkg::ClassW-1:0]   class_tag_i,
  input  logic                         set_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gbs_pkg::CoordW-1:0]   kept_x_o,
  output logic [gbs_pkg::CoordW-1:0]   kept_y_o,
  output logic [gbs_pkg::CoordW-1:0]   kept_width_o,
  output logic [gbs_pkg::CoordW-1:0]   kept_height_o,
  output logic [gbs_pkg::ScoreW-1:0]   kept_score_o,
  output logic [gbs_pkg::ClassW-1:0]   kept_class_o,
  output logic                         run_end_o
);
  import gbs_pkg::*;
  `include "greedy_box_suppression_assert.svh"

  localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_BOXES);
  localparam int unsigned SCW = ScoreW + ClassW;

  typedef enum logic [4:0] {
    S_LOAD, S_SORT_A, S_SORT_B, S_SORT_C, S_SORT_D, S_SORT_W,
    S_NMS_A, S_NMS_B, S_NMS_C, S_NMS_D, S_NMS_E, S_NMS_F, S_NMS_G,
    S_NMS_KEEP, S_NMS_NEXT, S_EMIT_A, S_EMIT_B, S_EMIT_C, S_EMIT_D
  } state_e;

  state_e state_q;

  // box storage and index lists
  geom_t          geom_mem  [MAX_BOXES];
  logic [SCW-1:0] sc_mem    [MAX_BOXES];
  logic [AW-1:0]  order_mem [MAX_BOXES];
  logic [AW-1:0]  kept_mem  [MAX_BOXES];

  geom_t          geom_rdata_q;
  logic [SCW-1:0] sc_rdata_q;
  logic [AW-1:0]  order_rdata_q, kept_rdata_q;

  logic [ThrW-1:0]   thr_q;
  logic [CW-1:0]     loaded_q, kept_cnt_q, i_q, j_q, k_q;
  logic [AW-1:0]     rank_q;
  logic [ScoreW-1:0] si_q;
  logic [AW-1:0]     cand_q;
  geom_t             p_q;
  ovl_req_t          ovl_req_q;
  ovl_rsp_t          ovl_rsp;

  logic              out_valid_q, run_end_q;
  geom_t             out_geom_q;
  logic [SCW-1:0]    out_sc_q;

  logic              in_acc, out_acc;
  logic [AW-1:0]     geom_raddr, sc_raddr;

  assign in_acc     = in_valid_i && (state_q == S_LOAD);
  assign in_stall_o = (state_q != S_LOAD);
  assign out_acc    = out_valid_q && !out_stall_i;

  // read address selection for the shared memory ports
  always_comb begin
    case (state_q)
      S_NMS_B: geom_raddr = order_rdata_q;
      default: geom_raddr = kept_rdata_q;
    endcase
    case (state_q)
      S_SORT_A: sc_raddr = i_q[AW-1:0];
      S_SORT_C: sc_raddr = j_q[AW-1:0];
      default:  sc_raddr = kept_rdata_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (loaded_q < MaxCnt)) begin
      geom_mem[loaded_q[AW-1:0]] <= '{h: box_height_i, w: box_width_i,
                                      y: box_y_i, x: box_x_i};
      sc_mem[loaded_q[AW-1:0]]   <= {class_tag_i, score_i};
    end
    if (state_q == S_SORT_W) begin
      order_mem[rank_q] <= i_q[AW-1:0];
    end
    if (state_q == S_NMS_KEEP) begin
      kept_mem[kept_cnt_q[AW-1:0]] <= cand_q;
    end
    geom_rdata_q  <= geom_mem[geom_raddr];
    sc_rdata_q    <= sc_mem[sc_raddr];
    order_rdata_q <= order_mem[i_q[AW-1:0]];
    kept_rdata_q  <= kept_mem[k_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  gbs_overlap u_overlap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ovl_req_q),
    .thr_i  (thr_q),
    .rsp_o  (ovl_rsp)
  );

  // sequencer: load, rank by counting, greedy check, emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      loaded_q    <= '0;
      kept_cnt_q  <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rank_q      <= '0;
      si_q        <= '0;
      cand_q      <= '0;
      p_q         <= '0;
      ovl_req_q   <= '0;
      out_valid_q <= 1'b0;
      run_end_q   <= 1'b0;
      out_geom_q  <= '0;
      out_sc_q    <= '0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (loaded_q < MaxCnt) begin
              loaded_q <= loaded_q + 1'b1;
            end
            if (set_end_i) begin
              i_q        <= '0;
              kept_cnt_q <= '0;
              state_q    <= S_SORT_A;
            end
          end
        end
        S_SORT_A: begin
          state_q <= S_SORT_B;
        end
        S_SORT_B: begin
          si_q    <= sc_rdata_q[ScoreW-1:0];
          j_q     <= '0;
          rank_q  <= '0;
          state_q <= S_SORT_C;
        end
        S_SORT_C: begin
          state_q <= S_SORT_D;
        end
        S_SORT_D: begin
          // earlier in order: higher score, or equal score and earlier arrival
          if ((sc_rdata_q[ScoreW-1:0] > si_q) ||
              ((sc_rdata_q[ScoreW-1:0] == si_q) && (j_q < i_q))) begin
            rank_q <= rank_q + 1'b1;
          end
          j_q     <= j_q + 1'b1;
          state_q <= (j_q + 1'b1 == loaded_q) ? S_SORT_W : S_SORT_C;
        end
        S_SORT_W: begin
          if (i_q + 1'b1 == loaded_q) begin
            i_q     <= '0;
            state_q <= S_NMS_A;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_SORT_A;
          end
        end
        S_NMS_A: begin
          state_q <= S_NMS_B;
        end
        S_NMS_B: begin
          cand_q  <= order_rdata_q;
          state_q <= S_NMS_C;
        end
        S_NMS_C: begin
          p_q     <= geom_rdata_q;
          k_q     <= '0;
          state_q <= (kept_cnt_q == '0) ? S_NMS_KEEP : S_NMS_D;
        end
        S_NMS_D: begin
          state_q <= S_NMS_E;
        end
        S_NMS_E: begin
          state_q <= S_NMS_F;
        end
        S_NMS_F: begin
          ovl_req_q <= '{valid: 1'b1, p: p_q, q: geom_rdata_q};
          state_q   <= S_NMS_G;
        end
        S_NMS_G: begin
          ovl_req_q.valid <= 1'b0;
          if (ovl_rsp.valid) begin
            if (ovl_rsp.drop) begin
              state_q <= S_NMS_NEXT;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= (k_q + 1'b1 == kept_cnt_q) ? S_NMS_KEEP : S_NMS_D;
            end
          end
        end
        S_NMS_KEEP: begin
          kept_cnt_q <= kept_cnt_q + 1'b1;
          state_q    <= S_NMS_NEXT;
        end
        S_NMS_NEXT: begin
          if (i_q + 1'b1 == loaded_q) begin
            k_q     <= '0;
            state_q <= S_EMIT_A;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_NMS_A;
          end
        end
        S_EMIT_A: begin
          state_q <= S_EMIT_B;
        end
        S_EMIT_B: begin
          state_q <= S_EMIT_C;
        end
        S_EMIT_C: begin
          out_geom_q  <= geom_rdata_q;
          out_sc_q    <= sc_rdata_q;
          run_end_q   <= (k_q + 1'b1 == kept_cnt_q);
          out_valid_q <= 1'b1;
          state_q     <= S_EMIT_D;
        end
        S_EMIT_D: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            k_q         <= k_q + 1'b1;
            if (k_q + 1'b1 == kept_cnt_q) begin
              loaded_q <= '0;
              state_q  <= S_LOAD;
            end else begin
              state_q <= S_EMIT_A;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kept_x_o      = out_geom_q.x;
  assign kept_y_o      = out_geom_q.y;
  assign kept_width_o  = out_geom_q.w;
  assign kept_height_o = out_geom_q.h;
  assign kept_score_o  = out_sc_q[ScoreW-1:0];
  assign kept_class_o  = out_sc_q[SCW-1:ScoreW];
  assign run_end_o     = run_end_q;

  `GBS_ASSERT(a_out_only_emit, clk_i, rst_ni, out_valid_q |-> (state_q == S_EMIT_D))
  `GBS_ASSERT(a_ovl_only_wait, clk_i, rst_ni, ovl_rsp.valid |-> (state_q == S_NMS_G))
  `GBS_ASSERT(a_kept_le_loaded, clk_i, rst_ni, kept_cnt_q <= loaded_q || state_q == S_LOAD)
  `GBS_ASSERT_NEXT(a_load_count, clk_i, rst_ni,
    in_acc && !set_end_i && (loaded_q < MaxCnt), loaded_q == $past(loaded_q) + 1'b1)
endmodule

/* rtl/gbs_overlap.sv */
// pipelined overlap ratio check of one candidate box against one kept box
`timescale 1ns / 1ps
module gbs_overlap (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gbs_pkg::ovl_req_t          req_i,
  input  logic [gbs_pkg::ThrW-1:0]   thr_i,
  output gbs_pkg::ovl_rsp_t          rsp_o
);
  import gbs_pkg::*;

  logic [4:0]        v_q;
  logic [16:0]       iw1_q, ih1_q;
  logic [15:0]       pw1_q, ph1_q, qw1_q, qh1_q;
  logic [33:0]       inter2_q;
  logic [31:0]       pa2_q, qa2_q;
  logic [33:0]       inter3_q, uni3_q;
  logic [48:0]       lhs4_q;
  logic [49:0]       rhs4_q;
  logic              drop5_q;

  logic [16:0] p_r, q_r, p_b, q_b, hi_x, hi_y, lo_x, lo_y, iw, ih;

  always_comb begin
    p_r  = {1'b0, req_i.p.x} + {1'b0, req_i.p.w};
    q_r  = {1'b0, req_i.q.x} + {1'b0, req_i.q.w};
    p_b  = {1'b0, req_i.p.y} + {1'b0, req_i.p.h};
    q_b  = {1'b0, req_i.q.y} + {1'b0, req_i.q.h};
    hi_x = (p_r < q_r) ? p_r : q_r;
    hi_y = (p_b < q_b) ? p_b : q_b;
    lo_x = (req_i.p.x > req_i.q.x) ? {1'b0, req_i.p.x} : {1'b0, req_i.q.x};
    lo_y = (req_i.p.y > req_i.q.y) ? {1'b0, req_i.p.y} : {1'b0, req_i.q.y};
    iw   = (hi_x > lo_x) ? hi_x - lo_x : '0;
    ih   = (hi_y > lo_y) ? hi_y - lo_y : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    iw1_q    <= iw;
    ih1_q    <= ih;
    pw1_q    <= req_i.p.w;
    ph1_q    <= req_i.p.h;
    qw1_q    <= req_i.q.w;
    qh1_q    <= req_i.q.h;
    inter2_q <= iw1_q * ih1_q;
    pa2_q    <= pw1_q * ph1_q;
    qa2_q    <= qw1_q * qh1_q;
    inter3_q <= inter2_q;
    uni3_q   <= {2'b00, pa2_q} + {2'b00, qa2_q} - inter2_q;
    lhs4_q   <= {inter3_q, 15'b0};
    rhs4_q   <= thr_i * uni3_q;
    drop5_q  <= {1'b0, lhs4_q} > rhs4_q;
  end

  assign rsp_o.valid = v_q[4];
  assign rsp_o.drop  = drop5_q;
endmodule

/* test/greedy_box_suppression_tb.sv */
// self-checking testbench for the greedy box suppression block
`timescale 1ns / 1ps
module greedy_box_suppression_tb;
  import gbs_pkg::*;

  localparam int unsigned MaxBoxes = 64;
  localparam int unsigned DrainCycles = 40;

  // one detection box as the block sees it
  typedef struct {
    logic [CoordW-1:0] x, y, w, h;
    logic [ScoreW-1:0] score;
    logic [ClassW-1:0] cls;
  } box_t;

  // one kept box word as it should leave the block
  typedef struct {
    box_t b;
    logic last;
  } kept_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [ThrW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CoordW-1:0] box_x_i = '0, box_y_i = '0, box_width_i = '0, box_height_i = '0;
  logic [ScoreW-1:0] score_i = '0;
  logic [ClassW-1:0] class_tag_i = '0;
  logic              set_end_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CoordW-1:0] kept_x_o, kept_y_o, kept_width_o, kept_height_o;
  logic [ScoreW-1:0] kept_score_o;
  logic [ClassW-1:0] kept_class_o;
  logic              run_end_o;

  greedy_box_suppression #(.MAX_BOXES(MaxBoxes)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .box_x_i, .box_y_i, .box_width_i, .box_height_i, .score_i, .class_tag_i,
    .set_end_i, .out_valid_o, .out_stall_i, .kept_x_o, .kept_y_o, .kept_width_o,
    .kept_height_o, .kept_score_o, .kept_class_o, .run_end_o
  );

  always #4 clk_i = ~clk_i;

  // predictor state: threshold, boxes gathered so far, kept words still due
  logic [ThrW-1:0] thr_model = ThrReset;
  box_t            pending_q[$];
  kept_t           kept_due_q[$];
  int              fail_count = 0;
  int              boxes_sent = 0;
  int              sets_sent = 0;
  int              words_seen = 0;
  bit              calm = 1'b0;   // no idling on either side while set

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // true when box p is suppressed by already kept box q
  function automatic bit too_close(box_t p, box_t q, logic [ThrW-1:0] thr);
    longint unsigned lo_x, lo_y, hi_x, hi_y, iw, ih, inter, uni, pr, qr, pb, qb;
    lo_x = 64'((p.x > q.x) ? p.x : q.x);
    lo_y = 64'((p.y > q.y) ? p.y : q.y);
    // right and bottom edges in wide arithmetic so nothing wraps
    pr = longint'(p.x) + p.w;  qr = longint'(q.x) + q.w;
    pb = longint'(p.y) + p.h;  qb = longint'(q.y) + q.h;
    hi_x = (pr < qr) ? pr : qr;
    hi_y = (pb < qb) ? pb : qb;
    iw = (hi_x > lo_x) ? hi_x - lo_x : 0;
    ih = (hi_y > lo_y) ? hi_y - lo_y : 0;
    inter = iw * ih;
    uni = longint'(p.w) * p.h + longint'(q.w) * q.h - inter;
    if (uni == 0) return 1'b0;   // degenerate pair never suppresses
    return (inter * 32768) > (longint'(thr) * uni);
  endfunction

  // model one accepted box; on set end rank, suppress and queue the kept words
  task automatic predict_box(box_t b, logic last);
    int order[$];
    box_t kept[$];
    int j;
    bit drop;
    kept_t k;
    if (pending_q.size() < MaxBoxes) pending_q = {pending_q, b};   // full store drops
    if (!last) return;
    // stable ranking, highest score first
    for (int i = 0; i < pending_q.size(); i++) begin
      j = 0;
      while (j < order.size() && pending_q[order[j]].score >= pending_q[i].score) j++;
      order.insert(j, i);
    end
    foreach (order[i]) begin
      drop = 1'b0;
      foreach (kept[m]) if (!drop) drop = too_close(pending_q[order[i]], kept[m], thr_model);
      if (!drop) kept = {kept, pending_q[order[i]]};
    end
    foreach (kept[m]) begin
      k.b = kept[m];
      k.last = (m == kept.size() - 1);
      kept_due_q = {kept_due_q, k};
    end
    pending_q.delete();
  endtask

  // drive one box word and wait for its acceptance
  task automatic send_box(box_t b, logic last);
    bit taken;
    int g;
    g = pick_gap();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    box_x_i      <= b.x;
    box_y_i      <= b.y;
    box_width_i  <= b.w;
    box_height_i <= b.h;
    score_i      <= b.score;
    class_tag_i  <= b.cls;
    set_end_i    <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predict_box(b, last);
    boxes_sent++;
    if (last) begin
      // the block is busy with the set now, so this cycle is never a lost slot
      sets_sent++;
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // wait until every kept word has come and the block has settled
  task automatic drain();
    while (kept_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // threshold write, only while idle
  task automatic write_threshold(logic [ThrW-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thr_model = v;
  endtask

  function automatic box_t mk_box(int x, int y, int w, int h, int s, int c);
    box_t b;
    b.x = CoordW'(x); b.y = CoordW'(y); b.w = CoordW'(w); b.h = CoordW'(h);
    b.score = ScoreW'(s); b.cls = ClassW'(c);
    return b;
  endfunction

  function automatic box_t rand_box();
    return mk_box($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 255));
  endfunction

  // boxes jittered around one spot so overlaps are frequent
  function automatic box_t near_box(box_t base);
    box_t b;
    b = base;
    b.x = CoordW'(base.x + $urandom_range(0, 255));
    b.y = CoordW'(base.y + $urandom_range(0, 255));
    b.w = CoordW'(base.w + $urandom_range(0, 255));
    b.h = CoordW'(base.h + $urandom_range(0, 255));
    b.score = ($urandom_range(0, 3) == 0) ? base.score : ScoreW'($urandom_range(0, 65535));
    b.cls = ClassW'($urandom_range(0, 255));
    return b;
  endfunction

  // a random set: mostly clustered, sometimes spread over the whole frame
  task automatic send_rand_set(int n);
    box_t base;
    base = mk_box($urandom_range(0, 64000), $urandom_range(0, 64000),
                  $urandom_range(0, 2048), $urandom_range(0, 2048),
                  $urandom_range(0, 65535), 0);
    for (int i = 0; i < n; i++)
      send_box(($urandom_range(0, 4) == 0) ? rand_box() : near_box(base), i == n - 1);
  endtask

  task automatic test_directed();
    // one lone box, all fields zero and all ones
    send_box(mk_box(0, 0, 0, 0, 0, 0), 1'b1);
    send_box(mk_box(65535, 65535, 65535, 65535, 65535, 255), 1'b1);
    // identical boxes: the first arrival wins the score tie
    send_box(mk_box(100, 100, 400, 400, 500, 1), 1'b0);
    send_box(mk_box(100, 100, 400, 400, 500, 2), 1'b0);
    send_box(mk_box(5000, 5000, 100, 100, 900, 3), 1'b1);
    // disjoint boxes all kept, zero-area boxes, edges past the frame
    send_box(mk_box(0, 0, 16, 16, 10, 4), 1'b0);
    send_box(mk_box(32, 32, 16, 16, 20, 5), 1'b0);
    send_box(mk_box(200, 200, 0, 0, 30, 6), 1'b0);
    send_box(mk_box(200, 200, 0, 0, 30, 7), 1'b0);
    send_box(mk_box(60000, 60000, 65535, 65535, 65535, 8), 1'b0);
    send_box(mk_box(61000, 61000, 65535, 65535, 40000, 9), 1'b1);
    // half overlap near the reset threshold
    send_box(mk_box(0, 0, 1000, 1000, 300, 10), 1'b0);
    send_box(mk_box(500, 0, 1000, 1000, 200, 11), 1'b0);
    send_box(mk_box(250, 0, 1000, 1000, 100, 12), 1'b1);
  endtask

  // extremes of the threshold with the same crowded set each time
  task automatic test_thresholds();
    logic [ThrW-1:0] vals[4] = '{16'd0, 16'd32768, 16'd65535, 16'd1};
    foreach (vals[i]) begin
      write_threshold(vals[i]);
      send_box(mk_box(0, 0, 1000, 1000, 300, 20), 1'b0);
      send_box(mk_box(0, 0, 1000, 1000, 200, 21), 1'b0);
      send_box(mk_box(999, 999, 1000, 1000, 100, 22), 1'b0);
      send_box(mk_box(5000, 0, 0, 1000, 50, 23), 1'b1);
    end
    write_threshold(ThrReset);
  endtask

  // a full store, then boxes that are dropped, the last one ending the set; then a set that just fills the store
  task automatic test_full_store();
    for (int i = 0; i < MaxBoxes + 2; i++) send_box(rand_box(), i == MaxBoxes + 1);
    for (int i = 0; i < MaxBoxes; i++) send_box(rand_box(), i == MaxBoxes - 1);
  endtask

  task automatic test_random();
    int n, r;
    while (boxes_sent < 310) begin
      if ($urandom_range(0, 9) == 0) write_threshold(ThrW'($urandom_range(0, 65535)));
      calm = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 19);
      n = (r == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      send_rand_set(n);
    end
    calm = 1'b0;
  endtask

  // receiver stalls at random
  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        g = pick_gap();
        out_stall_i <= 1'b1;
        repeat ((g < 1) ? 1 : g) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // check every accepted kept word against the oldest prediction
  initial begin
    kept_t e;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        words_seen++;
        if (kept_due_q.size() == 0) begin
          $display("%0t: unexpected word x=%0d score=%0d", $time, kept_x_o, kept_score_o);
          fail_count++;
        end else begin
          e = kept_due_q.pop_front();
          if ({kept_x_o, kept_y_o, kept_width_o, kept_height_o, kept_score_o,
               kept_class_o, run_end_o} !==
              {e.b.x, e.b.y, e.b.w, e.b.h, e.b.score, e.b.cls, e.last}) begin
            $display("%0t: mismatch exp x=%0d y=%0d w=%0d h=%0d s=%0d c=%0d e=%0d",
                     $time, e.b.x, e.b.y, e.b.w, e.b.h, e.b.score, e.b.cls, e.last);
            $display("%0t:          act x=%0d y=%0d w=%0d h=%0d s=%0d c=%0d e=%0d",
                     $time, kept_x_o, kept_y_o, kept_width_o, kept_height_o,
                     kept_score_o, kept_class_o, run_end_o);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("timeout with %0d kept words outstanding", kept_due_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_thresholds();
    test_full_store();
    test_random();
    drain();
    if (kept_due_q.size() != 0) fail_count++;
    $display("covered %0d boxes in %0d sets, %0d kept words checked", boxes_sent,
             sets_sent, words_seen);
    $display("including threshold extremes, full-store drops and random stalls");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/gbs_pkg.sv
rtl/gbs_overlap.sv
rtl/greedy_box_suppression.sv
test/greedy_box_suppression_tb.sv
